// ===== hw/rtl/rpt_pkg.sv =====
// Package for the reflection plane table: field widths, status codes,
// register indexes and the structs passed along the cell chain.
// No dependencies.
`default_nettype none

package rpt_pkg;

    // fixed field widths
    localparam int HEIGHT_W    = 28;
    localparam int DIST_W      = 24;
    localparam int TOL_W       = 16;
    localparam int CFG_CAP_W   = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;

    // stream word layout
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    // defaults
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CFG_CAP_W-1:0] CAP_RESET = 5'd1;
    localparam logic [TOL_W-1:0]     TOL_RESET = 16'd26;   // 0.1 in Q.8

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_TOL  = 1'd1;

    // opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_DISABLED  = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    // query travelling down the chain
    typedef struct packed {
        logic                       valid;
        logic                       dup_hit;
        logic                       rep_hit;
        logic signed [HEIGHT_W-1:0] height;
        logic [DIST_W-1:0]          view_dist;
    } t_probe;

    // entry write broadcast to all cells
    typedef struct packed {
        logic                       en;
        logic signed [HEIGHT_W-1:0] height;
        logic [DIST_W-1:0]          view_dist;
    } t_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/rpt_cell.sv =====
// One table entry plus one stage of the probe chain.
// Depends on rpt_pkg.
`default_nettype none

module rpt_cell
    import rpt_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [TOL_W-1:0] i_tol,
    input  wire t_probe           i_probe,
    input  wire logic [IDX_W-1:0] i_dup_slot,
    input  wire logic [IDX_W-1:0] i_rep_slot,
    output t_probe                o_probe,
    output logic      [IDX_W-1:0] o_dup_slot,
    output logic      [IDX_W-1:0] o_rep_slot,
    input  wire t_wr              i_wr,
    input  wire logic [IDX_W-1:0] i_wr_slot
);

    logic signed [HEIGHT_W-1:0] r_height;
    logic [DIST_W-1:0]          r_dist;
    t_probe                     r_probe;
    logic [IDX_W-1:0]           r_dup_slot;
    logic [IDX_W-1:0]           r_rep_slot;

    t_probe                     n_probe;
    logic [IDX_W-1:0]           n_dup_slot;
    logic [IDX_W-1:0]           n_rep_slot;

    logic                       w_live;
    logic signed [HEIGHT_W:0]   w_diff;
    logic [HEIGHT_W:0]          w_abs;
    logic                       w_near;
    logic                       w_farther;

    assign w_live    = CNT_W'(CELL_IDX) < i_count;
    assign w_diff    = {r_height[HEIGHT_W-1], r_height}
                     - {i_probe.height[HEIGHT_W-1], i_probe.height};
    assign w_abs     = w_diff[HEIGHT_W] ? -w_diff : w_diff;
    assign w_near    = w_abs < (HEIGHT_W+1)'(i_tol);
    assign w_farther = i_probe.view_dist < r_dist;

    always_comb begin
        n_probe    = i_probe;
        n_dup_slot = i_dup_slot;
        n_rep_slot = i_rep_slot;
        if (w_live && !i_probe.dup_hit && w_near) begin
            n_probe.dup_hit = 1'b1;
            n_dup_slot      = IDX_W'(CELL_IDX);
        end
        if (w_live && !i_probe.rep_hit && w_farther) begin
            n_probe.rep_hit = 1'b1;
            n_rep_slot      = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= i_probe.valid;
        end
        r_probe.dup_hit   <= n_probe.dup_hit;
        r_probe.rep_hit   <= n_probe.rep_hit;
        r_probe.height    <= n_probe.height;
        r_probe.view_dist <= n_probe.view_dist;
        r_dup_slot        <= n_dup_slot;
        r_rep_slot        <= n_rep_slot;
    end

    // entry storage, written only on commit of an add
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_slot == IDX_W'(CELL_IDX))) begin
            r_height <= i_wr.height;
            r_dist   <= i_wr.view_dist;
        end
    end

    assign o_probe    = r_probe;
    assign o_dup_slot = r_dup_slot;
    assign o_rep_slot = r_rep_slot;

endmodule

`default_nettype wire

// ===== hw/rtl/reflection_plane_table.sv =====
// Top level of the reflection plane table: config registers, control FSM,
// output register and the chain of entry cells.
// Depends on rpt_pkg and rpt_cell.
`default_nettype none

// Holds up to MAX_ENTRIES (height, distance) pairs, one per cell in a chain.
// An add word is injected at the head of the chain; each cell compares its
// own entry against the query (duplicate height within dup_tolerance, stored
// distance greater than the new one) and passes the query on, one cell per
// clock. When the query leaves the tail the first duplicate and first
// replacement candidates are known and at most one write is broadcast to the
// chosen cell. An add thus runs through the cell registers, its time set by
// the length of the chain, then through DONE and the output register; clear
// and disabled adds go straight from IDLE to DONE. One word is processed at a
// time; the result sits in an output register so the next input word is taken
// while it waits. Capacity above MAX_ENTRIES saturates. Send a clear after
// changing capacity. Entry storage has no reset; only entries below the valid count are ever read.
module reflection_plane_table
    import rpt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write port
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input words
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // height[27:0], view_distance[51:28]
    input  wire logic                   s_axis_tuser,   // opcode[0]
    // result words
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // slot[3:0], entry_count[8:4]
    output logic [STATUS_W-1:0]         m_axis_tuser    // status[2:0]
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // config registers
    logic [CFG_CAP_W-1:0] r_capacity;
    logic [TOL_W-1:0]     r_dup_tol;

    // control and pending result
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic signed [HEIGHT_W-1:0] r_height;
    logic [DIST_W-1:0]    r_dist;
    t_status              r_res_status, n_res_status;
    logic [IDX_W-1:0]     r_res_slot, n_res_slot;
    logic [CNT_W-1:0]     r_res_count, n_res_count;
    logic                 r_res_wr, n_res_wr;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [COUNT_W-1:0]   r_out_count;

    // chain wiring
    t_probe               w_probe    [MAX_ENTRIES+1];
    logic [IDX_W-1:0]     w_dup_slot [MAX_ENTRIES+1];
    logic [IDX_W-1:0]     w_rep_slot [MAX_ENTRIES+1];
    t_wr                  w_wr;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_commit;
    logic [CAP_W-1:0]     w_cap_ext;
    logic [CAP_W-1:0]     w_cap_eff;
    logic                 w_disabled;
    logic                 w_has_room;
    logic signed [HEIGHT_W-1:0] w_in_height;
    logic [DIST_W-1:0]    w_in_dist;

    assign w_in_height = s_axis_tdata[HEIGHT_W-1:0];
    assign w_in_dist   = s_axis_tdata[HEIGHT_W+DIST_W-1:HEIGHT_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_commit      = (r_state == S_DONE) && w_out_free;

    // effective capacity saturates at the table size
    assign w_cap_ext  = CAP_W'(r_capacity);
    assign w_cap_eff  = (w_cap_ext > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : w_cap_ext;
    assign w_disabled = (w_cap_eff == '0);
    assign w_has_room = CAP_W'(r_count) < w_cap_eff;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_dup_tol  <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_wdata[CFG_CAP_W-1:0];
                CFG_DUP_TOL:  r_dup_tol  <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // head of the chain: a fresh query with no hits
    always_comb begin
        w_probe[0].valid     = w_in_acc && (s_axis_tuser == OP_ADD) && !w_disabled;
        w_probe[0].dup_hit   = 1'b0;
        w_probe[0].rep_hit   = 1'b0;
        w_probe[0].height    = w_in_height;
        w_probe[0].view_dist = w_in_dist;
        w_dup_slot[0]        = '0;
        w_rep_slot[0]        = '0;
    end

    // write broadcast on commit
    assign w_wr.en        = w_commit && r_res_wr;
    assign w_wr.height    = r_height;
    assign w_wr.view_dist = r_dist;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        rpt_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_tol      (r_dup_tol),
            .i_probe    (w_probe[g]),
            .i_dup_slot (w_dup_slot[g]),
            .i_rep_slot (w_rep_slot[g]),
            .o_probe    (w_probe[g+1]),
            .o_dup_slot (w_dup_slot[g+1]),
            .o_rep_slot (w_rep_slot[g+1]),
            .i_wr       (w_wr),
            .i_wr_slot  (r_res_slot)
        );
    end

    // FSM and result decision
    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_count  = r_res_count;
        n_res_wr     = r_res_wr;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_slot  = '0;
                    n_res_wr    = 1'b0;
                    n_res_count = r_count;
                    if (s_axis_tuser == OP_CLEAR) begin
                        n_res_status = ST_CLEARED;
                        n_res_count  = '0;
                        n_state      = S_DONE;
                    end else if (w_disabled) begin
                        n_res_status = ST_DISABLED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // tail of the chain carries the complete scan result
                if (w_probe[MAX_ENTRIES].valid) begin
                    n_state = S_DONE;
                    priority if (w_probe[MAX_ENTRIES].dup_hit) begin
                        n_res_status = ST_DUPLICATE;
                        n_res_slot   = w_dup_slot[MAX_ENTRIES];
                    end else if (w_has_room) begin
                        n_res_status = ST_APPENDED;
                        n_res_slot   = IDX_W'(r_count);
                        n_res_count  = CNT_W'(r_count + CNT_W'(1));
                        n_res_wr     = 1'b1;
                    end else if (w_probe[MAX_ENTRIES].rep_hit) begin
                        n_res_status = ST_REPLACED;
                        n_res_slot   = w_rep_slot[MAX_ENTRIES];
                        n_res_wr     = 1'b1;
                    end else begin
                        n_res_status = ST_DROPPED;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_res_wr    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_res_wr <= n_res_wr;
            if (w_commit) begin
                r_count     <= r_res_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_count  <= n_res_count;
        if (w_in_acc) begin
            r_height <= w_in_height;
            r_dist   <= w_in_dist;
        end
        if (w_commit) begin
            r_out_status <= r_res_status;
            r_out_slot   <= SLOT_W'(r_res_slot);
            r_out_count  <= COUNT_W'(r_res_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_slot});

endmodule

`default_nettype wire

// ===== hw/rtl/rpt_checker.sv =====
// Port-level checks for the reflection plane table, bound to the top level.
// Depends on rpt_pkg.
`default_nettype none

module rpt_checker
    import rpt_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [STATUS_W-1:0]    m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // clear empties the table and names no slot
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CLEARED) |-> (m_axis_tdata == '0))
        else $error("clear did not report an empty table");

    // outcomes without a slot report slot zero
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser == ST_DROPPED) || (m_axis_tuser == ST_DISABLED))
            |-> (m_axis_tdata[SLOT_W-1:0] == '0))
        else $error("slot not zero for dropped or disabled");

    // an append lands on the slot equal to the old count, so the count is slot plus one
    a_append_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_APPENDED)
            |-> (m_axis_tdata[SLOT_W+3:SLOT_W] == SLOT_W'(m_axis_tdata[SLOT_W-1:0] + 4'd1)))
        else $error("append slot does not match entry count");

endmodule

bind reflection_plane_table rpt_checker u_rpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
